// ===== design/dssm_pkg.sv =====
// shared types and constants for the differential servo slew mixer
`default_nettype none

package dssm_pkg;

	localparam int unsigned PULSE_W = 12;
	localparam int unsigned STEP_W  = 18;
	localparam int unsigned LIMIT_W = 13;
	localparam int unsigned SLEW_W  = 12;
	localparam int unsigned ANGLE_W = 14;
	localparam int unsigned RATE_W  = 17;
	localparam int unsigned CFG_W   = 13;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [PULSE_W-1:0] PULSE_CENTER = 12'd1500;
	localparam logic [PULSE_W-1:0] PULSE_MIN    = 12'd500;
	localparam logic [PULSE_W-1:0] PULSE_MAX    = 12'd2500;

	// pulse = (PULSE_CENTER*216 + 25*q) / 216, q in 1/64 degree
	localparam int unsigned PULSE_DEN = 216;
	localparam logic signed [21:0] MIX_BIAS   = 22'(int'(PULSE_CENTER) * PULSE_DEN);
	localparam logic signed [21:0] MIX_GAIN   = 22'sd25;
	localparam logic signed [21:0] MIX_LO_LIM = 22'(int'(PULSE_MIN) * PULSE_DEN);
	localparam logic signed [21:0] MIX_HI_LIM = 22'((int'(PULSE_MAX) + 1) * PULSE_DEN - 1);

	// reciprocals for division by 27 and 25
	localparam int unsigned RECIP27_SH = 22;
	localparam logic [17:0] RECIP27    = 18'((2**RECIP27_SH + 26) / 27);
	localparam int unsigned RECIP25_SH = 24;
	localparam logic [19:0] RECIP25    = 20'((2**RECIP25_SH + 24) / 25);

	localparam logic [STEP_W-1:0]  STEP_RESET  = 18'd2048;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd2160;
	localparam logic [SLEW_W-1:0]  SLEW_RESET  = 12'd50;

	localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_LIMIT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_SLEW    = 2'd1;

	typedef enum logic {
		CMD_SET_TARGET = 1'b0,
		CMD_TICK       = 1'b1
	} cmd_t;

	typedef struct packed {
		logic        lo;
		logic        hi;
		logic [16:0] num;
	} mix_t;

endpackage

`default_nettype wire

// ===== design/differential_servo_slew_mixer.sv =====
// Differential wrist servo mixer with slew limiting, top level.
//
// Input stream (s_axis_*): one item per transfer. tuser carries the command
// (set targets and slew step, or one 20 ms tick); tdata carries both joint
// angles and both joint rates. Output stream (m_axis_*): one result per item
// with both current pulse widths and the settled flag.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data) for the
// angle limit and the minimum slew rate; the user must see that it is written
// only while the block is idle, as the block itself does not enforce this.
// A result passes through the input register, the mix stage and the result
// register. Throughput: one item every cycle while the receiver does not
// stall; the pulse registers update at the result stage.
// Reset clears the pipeline valids, sets all pulses to the centre position,
// the step to 8 us per tick and the registers to their defaults.
// When the receiver stalls, the result is held and the two earlier stages
// keep filling; s_axis_tready drops only once all three stages hold items.
`default_nettype none

module differential_servo_slew_mixer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output      logic        s_axis_tready,
	// joint5_angle, joint6_angle, joint5_rate, joint6_rate, zero pad
	input  wire logic [63:0] s_axis_tdata,
	// command
	input  wire logic [0:0]  s_axis_tuser,
	output      logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// pulse_a, pulse_b, settled, zero pad
	output      logic [31:0] m_axis_tdata,
	input  wire logic        cfg_we,
	input  wire logic [dssm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [dssm_pkg::CFG_W-1:0]     cfg_data
);
	import dssm_pkg::*;

	function automatic mix_t mix_front(logic signed [14:0] sum, logic [LIMIT_W-1:0] lim);
		logic signed [16:0] q;
		logic signed [16:0] l;
		logic signed [21:0] n;
		mix_t r;
		q = 17'(sum) + (17'(sum) <<< 1);
		l = $signed({2'b00, lim, 2'b00});
		if (q > l) begin
			q = l;
		end else if (q < -l) begin
			q = -l;
		end
		n = MIX_BIAS + 22'(q) * MIX_GAIN;
		r.lo  = n < MIX_LO_LIM;
		r.hi  = n > MIX_HI_LIM;
		r.num = n[19:3];
		return r;
	endfunction

	function automatic logic [PULSE_W-1:0] mix_back(mix_t m);
		logic [34:0] prod;
		logic [PULSE_W-1:0] p;
		prod = 35'(m.num) * 35'(RECIP27);
		p = prod[33:22];
		if (m.lo) begin
			p = PULSE_MIN;
		end else if (m.hi) begin
			p = PULSE_MAX;
		end
		return p;
	endfunction

	// floor(64*b/27) for b below 27
	function automatic logic [5:0] frac27(logic [4:0] b);
		logic [5:0] f;
		case (b)
			5'd0:    f = 6'd0;
			5'd1:    f = 6'd2;
			5'd2:    f = 6'd4;
			5'd3:    f = 6'd7;
			5'd4:    f = 6'd9;
			5'd5:    f = 6'd11;
			5'd6:    f = 6'd14;
			5'd7:    f = 6'd16;
			5'd8:    f = 6'd18;
			5'd9:    f = 6'd21;
			5'd10:   f = 6'd23;
			5'd11:   f = 6'd26;
			5'd12:   f = 6'd28;
			5'd13:   f = 6'd30;
			5'd14:   f = 6'd33;
			5'd15:   f = 6'd35;
			5'd16:   f = 6'd37;
			5'd17:   f = 6'd40;
			5'd18:   f = 6'd42;
			5'd19:   f = 6'd45;
			5'd20:   f = 6'd47;
			5'd21:   f = 6'd49;
			5'd22:   f = 6'd52;
			5'd23:   f = 6'd54;
			5'd24:   f = 6'd56;
			5'd25:   f = 6'd59;
			5'd26:   f = 6'd61;
			default: f = 6'd0;
		endcase
		return f;
	endfunction

	function automatic logic [PULSE_W-1:0] move_toward(logic [PULSE_W-1:0] cur,
			logic [PULSE_W-1:0] tgt, logic [STEP_W-1:0] step);
		logic [PULSE_W-1:0] up;
		logic [PULSE_W-1:0] dn;
		logic [PULSE_W-1:0] nxt;
		up = 12'(step[17:8]);
		dn = up + 12'(|step[7:0]);
		if (tgt >= cur) begin
			nxt = ((tgt - cur) <= up) ? tgt : cur + up;
		end else begin
			nxt = ((cur - tgt) <= up) ? tgt : cur - dn;
		end
		return nxt;
	endfunction

	function automatic logic [RATE_W-1:0] rate_mag(logic signed [RATE_W-1:0] v);
		logic signed [RATE_W:0] w;
		w = 18'(v);
		return (w < 0) ? 17'(-w) : 17'(w);
	endfunction

	// configuration
	logic [LIMIT_W-1:0] angle_limit_q;
	logic [SLEW_W-1:0]  min_slew_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_limit_q <= LIMIT_RESET;
			min_slew_q    <= SLEW_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ANGLE_LIMIT: angle_limit_q <= cfg_data[LIMIT_W-1:0];
				CFG_MIN_SLEW:    min_slew_q    <= cfg_data[SLEW_W-1:0];
				default: ;
			endcase
		end
	end

	// pipeline control
	logic valid_s1, valid_s2, out_valid_q;
	logic out_open, s2_open, s2_fire;

	assign out_open      = !out_valid_q || m_axis_tready;
	assign s2_open       = !valid_s2 || out_open;
	assign s2_fire       = valid_s2 && out_open;
	assign s_axis_tready = !valid_s1 || s2_open;
	assign m_axis_tvalid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (s2_open) begin
				valid_s2 <= valid_s1;
			end
			if (out_open) begin
				out_valid_q <= valid_s2;
			end
		end
	end

	// input register
	cmd_t                      cmd_s1;
	logic signed [ANGLE_W-1:0] a5_s1, a6_s1;
	logic signed [RATE_W-1:0]  r5_s1, r6_s1;

	always_ff @(posedge clk) begin
		if (s_axis_tready) begin
			cmd_s1 <= cmd_t'(s_axis_tuser[0]);
			a5_s1  <= s_axis_tdata[13:0];
			a6_s1  <= s_axis_tdata[27:14];
			r5_s1  <= s_axis_tdata[44:28];
			r6_s1  <= s_axis_tdata[61:45];
		end
	end

	// mix front end, rate magnitude and reciprocal products
	mix_t              mix_a_c, mix_b_c;
	logic [RATE_W-1:0] mag5_c, mag6_c, rmax_c;
	logic [34:0]       rate_prod_c;
	logic [38:0]       slew_prod_c;

	always_comb begin
		mix_a_c     = mix_front(15'(a5_s1) + 15'(a6_s1), angle_limit_q);
		mix_b_c     = mix_front(15'(a6_s1) - 15'(a5_s1), angle_limit_q);
		mag5_c      = rate_mag(r5_s1);
		mag6_c      = rate_mag(r6_s1);
		rmax_c      = (mag5_c > mag6_c) ? mag5_c : mag6_c;
		rate_prod_c = 35'(rmax_c) * 35'(RECIP27);
		slew_prod_c = 39'({min_slew_q, 7'b0}) * 39'(RECIP25);
	end

	cmd_t              cmd_s2;
	mix_t              mix_a_s2, mix_b_s2;
	logic [RATE_W-1:0] rmax_s2;
	logic [11:0]       quo_s2;
	logic [14:0]       slew_s2;

	always_ff @(posedge clk) begin
		if (s2_open) begin
			cmd_s2   <= cmd_s1;
			mix_a_s2 <= mix_a_c;
			mix_b_s2 <= mix_b_c;
			rmax_s2  <= rmax_c;
			quo_s2   <= rate_prod_c[33:22];
			slew_s2  <= slew_prod_c[38:24];
		end
	end

	// pulse state
	logic [PULSE_W-1:0] cur_a_q, cur_b_q, tgt_a_q, tgt_b_q;
	logic [STEP_W-1:0]  step_q;
	logic [PULSE_W-1:0] cur_a_d, cur_b_d, tgt_a_d, tgt_b_d;
	logic [STEP_W-1:0]  step_d, rate_step_c;
	logic [RATE_W-1:0]  rem_c;

	always_comb begin
		cur_a_d     = cur_a_q;
		cur_b_d     = cur_b_q;
		tgt_a_d     = tgt_a_q;
		tgt_b_d     = tgt_b_q;
		step_d      = step_q;
		rem_c       = rmax_s2 - 17'(quo_s2) * 17'd27;
		rate_step_c = {quo_s2, 6'b0} + 18'(frac27(rem_c[4:0]));
		case (cmd_s2)
			CMD_SET_TARGET: begin
				tgt_a_d = mix_back(mix_a_s2);
				tgt_b_d = mix_back(mix_b_s2);
				step_d  = (rate_step_c > 18'(slew_s2)) ? rate_step_c : 18'(slew_s2);
			end
			CMD_TICK: begin
				cur_a_d = move_toward(cur_a_q, tgt_a_q, step_q);
				cur_b_d = move_toward(cur_b_q, tgt_b_q, step_q);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_a_q <= PULSE_CENTER;
			cur_b_q <= PULSE_CENTER;
			tgt_a_q <= PULSE_CENTER;
			tgt_b_q <= PULSE_CENTER;
			step_q  <= STEP_RESET;
		end else if (s2_fire) begin
			cur_a_q <= cur_a_d;
			cur_b_q <= cur_b_d;
			tgt_a_q <= tgt_a_d;
			tgt_b_q <= tgt_b_d;
			step_q  <= step_d;
		end
	end

	// the pulse registers double as the result register
	assign m_axis_tdata = {7'b0, (cur_a_q == tgt_a_q) && (cur_b_q == tgt_b_q), cur_b_q, cur_a_q};

endmodule

`default_nettype wire

// ===== design/dssm_checker.sv =====
// port-level checks for the differential servo slew mixer, with bind
`default_nettype none

module dssm_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tready,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [31:0] m_axis_tdata
);
	import dssm_pkg::*;

	// result held while the receiver stalls
	a_valid_held: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result dropped while stalled");

	a_data_held: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// pulses stay within the servo range
	a_pulse_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[11:0] >= PULSE_MIN && m_axis_tdata[11:0] <= PULSE_MAX
			&& m_axis_tdata[23:12] >= PULSE_MIN && m_axis_tdata[23:12] <= PULSE_MAX)
		else $error("pulse out of range");

	// input only refused when a result is backed up
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input refused without output stall");

endmodule

bind differential_servo_slew_mixer dssm_checker u_dssm_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
